// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the filter.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a reset that disables checking.
`define CHK_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Same, for modules whose clock and reset are named clock and reset.
`define CHK_ASSERT_CR(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`endif

// ===== design/biquad_pkg.sv =====
// Shared constants and types for the biquad filter.
// No dependencies; used by the interfaces, controller, datapath and top level.
package biquad_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COEF_WIDTH_DEF   = 18;
   localparam int FRAC_BITS_DEF    = 14;

   localparam int NUM_REGS    = 6;
   localparam int CSR_INDEX_W = 3;

   // Register indexes; also used to pick the multiplier operands.
   localparam logic [CSR_INDEX_W-1:0] REG_FWD0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FWD1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FWD2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FBK1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FBK2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN = 3'd5;

   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   typedef struct packed {
      logic                   latch_x;
      logic [CSR_INDEX_W-1:0] mul_sel;
      logic [1:0]             acc_op;
      logic                   commit;
   } cmd_type;

endpackage

// ===== design/biquad_if.sv =====
// Valid/ready channel interfaces for filter samples and results.
// Depends on biquad_pkg for default widths.
interface biquad_req_if #(
   parameter int SAMPLE_WIDTH = biquad_pkg::SAMPLE_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface biquad_rsp_if #(
   parameter int SAMPLE_WIDTH = biquad_pkg::SAMPLE_WIDTH_DEF
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample_out;
   logic                    clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== design/biquad_ctrl.sv =====
// Sequencer for the biquad: steps one item through the shared multiplier.
// Depends on biquad_pkg for the command struct and operand codes.
module biquad_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output biquad_pkg::cmd_type cmd
);
   import biquad_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [2:0] STEP_MUL_B0   = 3'd0;
   localparam logic [2:0] STEP_MUL_B1   = 3'd1;
   localparam logic [2:0] STEP_MUL_B2   = 3'd2;
   localparam logic [2:0] STEP_MUL_A1   = 3'd3;
   localparam logic [2:0] STEP_MUL_GAIN = 3'd4;
   localparam logic [2:0] STEP_MUL_A2   = 3'd5;
   localparam logic [2:0] STEP_ADD_LAST = 3'd6;
   localparam logic [2:0] STEP_SAT      = 3'd7;

   logic       state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free, last, commit, accept;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last      = (state_ff == ST_RUN) && (step_ff == STEP_SAT);
   assign commit    = last && slot_free;
   // A new item may enter in the same cycle the previous one is written out.
   assign req_ready = (state_ff == ST_IDLE) || commit;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);
      if (accept) begin
         state_in = ST_RUN;
         step_in  = STEP_MUL_B0;
      end else if (commit) begin
         state_in = ST_IDLE;
      end else if (state_ff == ST_RUN && !last) begin
         step_in = step_ff + 3'd1;
      end
   end

   always_comb begin
      cmd.latch_x = accept;
      cmd.commit  = commit;
      cmd.mul_sel = REG_FWD0;
      cmd.acc_op  = ACC_HOLD;
      if (state_ff == ST_RUN) begin
         case (step_ff)
            STEP_MUL_B0: begin
               cmd.mul_sel = REG_FWD0;
            end
            STEP_MUL_B1: begin
               cmd.mul_sel = REG_FWD1;
               cmd.acc_op  = ACC_LOAD;
            end
            STEP_MUL_B2: begin
               cmd.mul_sel = REG_FWD2;
               cmd.acc_op  = ACC_ADD;
            end
            STEP_MUL_A1: begin
               cmd.mul_sel = REG_FBK1;
               cmd.acc_op  = ACC_ADD;
            end
            // The feedforward sum is complete here; its feedback product restarts the sum.
            STEP_MUL_GAIN: begin
               cmd.mul_sel = REG_GAIN;
               cmd.acc_op  = ACC_LOAD;
            end
            STEP_MUL_A2: begin
               cmd.mul_sel = REG_FBK2;
               cmd.acc_op  = ACC_ADD;
            end
            STEP_ADD_LAST: begin
               cmd.acc_op = ACC_ADD;
            end
            default: begin
               cmd.acc_op = ACC_HOLD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_MUL_B0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/biquad_dp.sv =====
// Datapath of the biquad: coefficients, history, one multiplier and accumulator.
// Depends on biquad_pkg for the command struct and register indexes.
module biquad_dp #(
   parameter int SAMPLE_WIDTH = biquad_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = biquad_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS    = biquad_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [biquad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]              csr_wdata,
   input  logic [SAMPLE_WIDTH-1:0]            sample_in,
   input  biquad_pkg::cmd_type                cmd,
   output logic [SAMPLE_WIDTH-1:0]            sample_out,
   output logic                               clipped
);
   import biquad_pkg::*;

   localparam int FF_SUM_W = (COEF_WIDTH + SAMPLE_WIDTH + 2 > 64) ? 64
                             : COEF_WIDTH + SAMPLE_WIDTH + 2;
   localparam int FF_W     = (FF_SUM_W > FRAC_BITS) ? FF_SUM_W - FRAC_BITS : 1;
   localparam int MB_W     = (FF_W > SAMPLE_WIDTH) ? FF_W : SAMPLE_WIDTH;
   localparam int PROD_W   = COEF_WIDTH + MB_W;
   localparam int ACC_W    = (PROD_W + 2 > 64) ? 64 : PROD_W + 2;

   localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << FRAC_BITS);
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

   logic signed [COEF_WIDTH-1:0]   coef_ff [NUM_REGS];
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x1_ff, x2_ff, y1_ff, y2_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [ACC_W-1:0]        acc_sh;
   logic signed [COEF_WIDTH-1:0]   a_op;
   logic signed [MB_W-1:0]         b_op;
   logic [SAMPLE_WIDTH-1:0]        sample_out_ff, y_in;
   logic                           clipped_ff, clip_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_FWD0] <= COEF_ONE;
         coef_ff[REG_FWD1] <= '0;
         coef_ff[REG_FWD2] <= '0;
         coef_ff[REG_FBK1] <= '0;
         coef_ff[REG_FBK2] <= '0;
         coef_ff[REG_GAIN] <= COEF_ONE;
      end else if (csr_we && csr_index < CSR_INDEX_W'(NUM_REGS)) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // Arithmetic shift gives both the feedforward term and the final output.
   assign acc_sh = acc_ff >>> FRAC_BITS;

   always_comb begin
      case (cmd.mul_sel)
         REG_FWD0: begin
            a_op = coef_ff[REG_FWD0];
            b_op = MB_W'(x_ff);
         end
         REG_FWD1: begin
            a_op = coef_ff[REG_FWD1];
            b_op = MB_W'(x1_ff);
         end
         REG_FWD2: begin
            a_op = coef_ff[REG_FWD2];
            b_op = MB_W'(x2_ff);
         end
         REG_FBK1: begin
            a_op = coef_ff[REG_FBK1];
            b_op = MB_W'(y1_ff);
         end
         REG_FBK2: begin
            a_op = coef_ff[REG_FBK2];
            b_op = MB_W'(y2_ff);
         end
         REG_GAIN: begin
            a_op = coef_ff[REG_GAIN];
            b_op = MB_W'(acc_sh);
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = ACC_W'(prod_ff);
         ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   always_comb begin
      clip_in = 1'b0;
      y_in    = acc_sh[SAMPLE_WIDTH-1:0];
      if (acc_sh > SAT_HI) begin
         clip_in = 1'b1;
         y_in    = Y_MAX;
      end else if (acc_sh < SAT_LO) begin
         clip_in = 1'b1;
         y_in    = Y_MIN;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_op * b_op;
      acc_ff  <= acc_in;
      if (cmd.latch_x) begin
         x_ff <= sample_in;
      end
      if (cmd.commit) begin
         sample_out_ff <= y_in;
         clipped_ff    <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (cmd.commit) begin
         x1_ff <= x_ff;
         x2_ff <= x1_ff;
         y1_ff <= y_in;
         y2_ff <= y1_ff;
      end
   end

   assign sample_out = sample_out_ff;
   assign clipped    = clipped_ff;

endmodule

// ===== design/second_order_iir_filter.sv =====
// Direct-form-I biquad with one shared multiplier, one product per cycle.
// Each accepted sample takes six products and two accumulate/saturate
// steps through the single multiplier and accumulator, in sequence.
// A new sample is taken while idle or as the last result is written out.
// Synchronous reset clears the history and restores the coefficient defaults.
module second_order_iir_filter #(
   parameter int SAMPLE_WIDTH = biquad_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = biquad_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS    = biquad_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   biquad_req_if.sink                         req_ch,
   biquad_rsp_if.source                       rsp_ch,
   input  logic                               csr_we,
   input  logic [biquad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]              csr_wdata
);
   import biquad_pkg::*;

   cmd_type                 cmd;
   logic                    req_ready;
   logic                    rsp_valid;
   logic [SAMPLE_WIDTH-1:0] sample_out;
   logic                    clipped;

   biquad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   biquad_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sample_in  (req_ch.sample_in),
      .cmd        (cmd),
      .sample_out (sample_out),
      .clipped    (clipped)
   );

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.sample_out = sample_out;
   assign rsp_ch.clipped    = clipped;

endmodule

// ===== design/biquad_chk.sv =====
// Port-level checker for the biquad filter, attached by bind.
// Depends on assert_macros.svh and the top level second_order_iir_filter.
`include "assert_macros.svh"

module biquad_chk #(
   parameter int SAMPLE_WIDTH = biquad_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input logic                    rsp_clipped
);
   localparam logic [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

   logic [1:0] count_ff, count_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Items accepted but not yet delivered: at most one in work and one waiting.
   always_comb begin
      count_in = count_ff;
      if (req_acc && !rsp_acc) begin
         count_in = count_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
   `CHK_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_sample_out) && $stable(rsp_clipped), "result changed while stalled")
   `CHK_ASSERT_CR(a_clip_bound, rsp_valid && rsp_clipped |-> rsp_sample_out == Y_MAX || rsp_sample_out == Y_MIN, "clipped result is not at a bound")
   `CHK_ASSERT_CR(a_no_phantom, rsp_valid |-> count_ff != 2'd0, "result shown with no item outstanding")
   `CHK_ASSERT_CR(a_depth, count_ff != 2'd3, "more than two items outstanding")

endmodule

bind second_order_iir_filter biquad_chk #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_sample_out (rsp_ch.sample_out),
   .rsp_clipped    (rsp_ch.clipped)
);
